>>> rtl/core/dst_pkg.sv
// Shared types, widths and codes for the debounced Schmitt trigger unit.
// No dependencies; every other file in rtl/core imports this package.
package dst_pkg;

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int RUN_W       = 8;
  localparam int ERR_W       = 3;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 1 + ERR_W + 2 * RUN_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Run counters saturate here
  localparam logic [RUN_W-1:0] MAX_RUN = 8'd255;

  // Trigger modes
  localparam logic [MODE_W-1:0] MODE_RISING  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FALLING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD     = 2'd3;

  // Error codes, lowest non-zero code has highest priority
  localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NEG_THR = 3'd1;
  localparam logic [ERR_W-1:0] ERR_ORDER   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NEG_REF = 3'd3;
  localparam logic [ERR_W-1:0] ERR_DEBOUNCE = 3'd4;
  localparam logic [ERR_W-1:0] ERR_MODE    = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DB    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DB  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE   = 3'd5;

  // Input word kinds (carried on tuser)
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // Settings seen by the update logic
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SAMPLE_W-1:0] press_thr;
    logic [SAMPLE_W-1:0] release_thr;
    logic [RUN_W-1:0]    press_db;
    logic [RUN_W-1:0]    release_db;
    logic [ERR_W-1:0]    err;
  } dst_cfg_t;

  // Trigger state
  typedef struct packed {
    logic             status;
    logic [RUN_W-1:0] press_run;
    logic [RUN_W-1:0] release_run;
  } dst_state_t;

endpackage

>>> rtl/core/dst_cfg.sv
// Configuration registers and the prioritized settings check.
// Depends on dst_pkg.
module dst_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dst_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dst_pkg::dst_cfg_t             cfg
);
  import dst_pkg::*;

  logic [MODE_W-1:0]   mode_r;
  logic [SAMPLE_W-1:0] press_thr_r;
  logic [SAMPLE_W-1:0] release_thr_r;
  logic [RUN_W-1:0]    press_db_r;
  logic [RUN_W-1:0]    release_db_r;
  logic [SAMPLE_W-1:0] ref_r;
  logic [ERR_W-1:0]    err;
  logic                thr_neg;
  logic                order_bad;
  logic                db_bad;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RISING;
      press_thr_r   <= '0;
      release_thr_r <= '0;
      press_db_r    <= RUN_W'(1);
      release_db_r  <= RUN_W'(1);
      ref_r         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:        mode_r        <= cfg_wdata[MODE_W-1:0];
        REG_PRESS_THR:   press_thr_r   <= cfg_wdata[SAMPLE_W-1:0];
        REG_RELEASE_THR: release_thr_r <= cfg_wdata[SAMPLE_W-1:0];
        REG_PRESS_DB:    press_db_r    <= cfg_wdata[RUN_W-1:0];
        REG_RELEASE_DB:  release_db_r  <= cfg_wdata[RUN_W-1:0];
        REG_REFERENCE:   ref_r         <= cfg_wdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Settings check, first match wins
  always_comb begin
    thr_neg   = press_thr_r[SAMPLE_W-1] | release_thr_r[SAMPLE_W-1];
    order_bad = ((mode_r == MODE_RISING) &&
                 ($signed(press_thr_r) < $signed(release_thr_r))) ||
                ((mode_r == MODE_FALLING) &&
                 ($signed(press_thr_r) > $signed(release_thr_r)));
    db_bad    = (press_db_r == '0) || (press_db_r > MAX_RUN) ||
                (release_db_r == '0) || (release_db_r > MAX_RUN);
    if (thr_neg)                  err = ERR_NEG_THR;
    else if (order_bad)           err = ERR_ORDER;
    else if (ref_r[SAMPLE_W-1])   err = ERR_NEG_REF;
    else if (db_bad)              err = ERR_DEBOUNCE;
    else if (mode_r == MODE_BAD)  err = ERR_MODE;
    else                          err = ERR_OK;
  end

  assign cfg = '{mode: mode_r, press_thr: press_thr_r, release_thr: release_thr_r,
                 press_db: press_db_r, release_db: release_db_r, err: err};

endmodule

>>> rtl/core/dst_core.sv
// Trigger state registers and the per-word update (compare, count, switch).
// Depends on dst_pkg.
module dst_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         func,
  input  logic [dst_pkg::SAMPLE_W-1:0] sample,
  input  dst_pkg::dst_cfg_t            cfg,
  output dst_pkg::dst_state_t          st_nxt
);
  import dst_pkg::*;

  dst_state_t       st_r;
  logic             rising;
  logic             press_hit;
  logic             release_hit;
  logic [RUN_W-1:0] press_bump;
  logic [RUN_W-1:0] release_bump;

  // Compares and saturating increments
  always_comb begin
    rising       = (cfg.mode == MODE_RISING);
    press_hit    = rising ? ($signed(sample) >= $signed(cfg.press_thr))
                          : ($signed(sample) <= $signed(cfg.press_thr));
    release_hit  = rising ? ($signed(sample) < $signed(cfg.release_thr))
                          : ($signed(sample) > $signed(cfg.release_thr));
    press_bump   = (st_r.press_run == MAX_RUN) ? MAX_RUN : st_r.press_run + RUN_W'(1);
    release_bump = (st_r.release_run == MAX_RUN) ? MAX_RUN
                                                 : st_r.release_run + RUN_W'(1);
  end

  // Next state for the word in flight
  always_comb begin
    st_nxt = st_r;
    if (func == FUNC_CLEAR) begin
      st_nxt = '0;
    end else if (cfg.err == ERR_OK && (cfg.mode inside {MODE_RISING, MODE_FALLING})) begin
      if (!st_r.status) begin
        if (!press_hit) begin
          st_nxt.press_run = '0;
        end else if (press_bump >= cfg.press_db) begin
          st_nxt.status    = 1'b1;
          st_nxt.press_run = '0;
        end else begin
          st_nxt.press_run = press_bump;
        end
      end else begin
        if (!release_hit) begin
          st_nxt.release_run = '0;
        end else if (release_bump >= cfg.release_db) begin
          st_nxt.status      = 1'b0;
          st_nxt.release_run = '0;
        end else begin
          st_nxt.release_run = release_bump;
        end
      end
    end
  end

  // State commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> rtl/core/debounced_schmitt_trigger_unit.sv
// Top level of the debounced Schmitt trigger: input register, update, result register.
// Depends on dst_pkg, dst_cfg and dst_core.
//
//  port group | dir | handshake        | payload
//  in_*       | in  | tvalid / tready  | tuser: func; tdata: sample
//  out_*      | out | tvalid / tready  | tdata: status, error_code, press_run, release_run
//  cfg_*      | in  | we (no wait)     | index, wdata
//
// One word per cycle sustained while out_tready stays high; a taken word passes the input
// register, then the update into the result register, before out_tvalid rises with its result.
// The state update (two compares and a saturating 8-bit increment per counter) sits between
// the input register and the result register. Reset is synchronous: state clears to zero,
// settings go to their defaults. A stalled result holds while one more word waits
// in the input register; in_tready falls only when both are full.
module debounced_schmitt_trigger_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dst_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  input  logic                            in_tuser,   // [0] func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dst_pkg::OUT_TDATA_W-1:0] out_tdata,  // [0] status, [3:1] error_code,
                                                      // [11:4] press_run, [19:12] release_run
  input  logic                            cfg_we,
  input  logic [dst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dst_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dst_pkg::*;

  dst_cfg_t               cfg;
  dst_state_t             st_nxt;
  logic                   s1_valid_r;
  logic                   s1_func_r;
  logic [SAMPLE_W-1:0]    s1_sample_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   step;
  logic                   in_fire;

  dst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dst_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .func   (s1_func_r),
    .sample (s1_sample_r),
    .cfg    (cfg),
    .st_nxt (st_nxt)
  );

  // Flow control
  assign step      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || step;
  assign in_fire   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r   <= in_tuser;
      s1_sample_r <= in_tdata[SAMPLE_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= OUT_TDATA_W'({st_nxt.release_run, st_nxt.press_run, cfg.err,
                                  st_nxt.status});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/core/dst_checker.sv
// Port-level checks for the debounced Schmitt trigger unit, bound to the top level.
// Depends on dst_pkg and debounced_schmitt_trigger_unit.
module dst_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dst_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dst_pkg::*;

  logic             status;
  logic [ERR_W-1:0] err;
  logic [RUN_W-1:0] press_run;
  logic [RUN_W-1:0] release_run;

  assign status      = out_tdata[0];
  assign err         = out_tdata[ERR_W:1];
  assign press_run   = out_tdata[ERR_W+RUN_W:ERR_W+1];
  assign release_run = out_tdata[ERR_W+2*RUN_W:ERR_W+RUN_W+1];

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // No result the cycle after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Error code stays within its defined codes
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> err <= ERR_MODE)
    else $error("undefined error code");

  // Only the counter for the current status may be non-zero
  a_idle_ctr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (status ? (press_run == '0) : (release_run == '0)))
    else $error("counter of the inactive side is non-zero");

  // A counter that reaches the limit always switches and clears
  a_no_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (press_run != MAX_RUN) && (release_run != MAX_RUN))
    else $error("run counter left at its limit");

endmodule

bind debounced_schmitt_trigger_unit dst_checker u_dst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
